// ===== hdl/socks5_client_handshake_top_assert.svh =====
// ----------------------------------------------------------------------------
// SOCKS5 client handshake assertion macros
// Shared concurrent assertion forms for the handshake checker.
// ----------------------------------------------------------------------------
`ifndef SOCKS5_CLIENT_HANDSHAKE_TOP_ASSERT_SVH
`define SOCKS5_CLIENT_HANDSHAKE_TOP_ASSERT_SVH

// Same-cycle implication, ignored while in reset.
`define S5CH_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("s5ch same-cycle check failed");

// Next-cycle implication, ignored while in reset.
`define S5CH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("s5ch next-cycle check failed");

`endif

// ===== hdl/s5ch_pkg.sv =====
// ----------------------------------------------------------------------------
// s5ch_pkg
// Types and constants shared by the SOCKS5 client handshake modules.
// ----------------------------------------------------------------------------
package s5ch_pkg;

  typedef enum logic [2:0] {
    PH_IDLE, PH_GREET, PH_ADDR, PH_HDR, PH_BLEN, PH_SKIP
  } phase_t;

  typedef enum logic [1:0] {
    OP_START, OP_ADDR_BYTE, OP_RX_BYTE, OP_TICK
  } opcode_t;

  typedef enum logic [1:0] {
    BK_GREET, BK_HDR, BK_ADDR, BK_STATUS
  } burst_t;

  // status report codes
  localparam logic [2:0] ST_DONE       = 3'd0;
  localparam logic [2:0] ST_BAD_GREET  = 3'd1;
  localparam logic [2:0] ST_BAD_VER    = 3'd2;
  localparam logic [2:0] ST_REFUSED    = 3'd3;
  localparam logic [2:0] ST_BAD_TYPE   = 3'd4;
  localparam logic [2:0] ST_TIMEOUT    = 3'd5;
  localparam logic [2:0] ST_UNEXPECTED = 3'd6;

  // result kinds
  localparam logic RK_BYTE   = 1'b0;
  localparam logic RK_STATUS = 1'b1;

  // address kinds on start
  localparam logic [1:0] AK_V4      = 2'd0;
  localparam logic [1:0] AK_V6      = 2'd1;
  localparam logic [1:0] AK_NAME    = 2'd2;
  localparam logic [1:0] AK_INVALID = 2'd3;

  // protocol bytes
  localparam logic [7:0] SOCKS_VER    = 8'h05;
  localparam logic [7:0] METHOD_COUNT = 8'h01;
  localparam logic [7:0] AUTH_NONE    = 8'h00;
  localparam logic [7:0] REQ_CONNECT  = 8'h01;
  localparam logic [7:0] RSV_BYTE     = 8'h00;
  localparam logic [7:0] REPLY_OK     = 8'h00;
  localparam logic [7:0] ATYP_V4      = 8'h01;
  localparam logic [7:0] ATYP_NAME    = 8'h03;
  localparam logic [7:0] ATYP_V6      = 8'h04;

  localparam logic [7:0] LEN_V4    = 8'd4;
  localparam logic [7:0] LEN_V6    = 8'd16;
  localparam logic [8:0] SKIP_V4   = 9'd6;
  localparam logic [8:0] SKIP_V6   = 9'd18;
  localparam logic [8:0] SKIP_PORT = 9'd2;

  // one burst of results, as handed from front to back
  typedef struct packed {
    burst_t      kind;
    logic [7:0]  first;      // ATYP for header, address byte for address
    logic        has_len;
    logic [7:0]  len;
    logic        with_port;
    logic [15:0] port;
    logic [2:0]  status;
    logic [7:0]  code;
  } burst_desc_t;

  function automatic logic [7:0] atyp_code(input logic [1:0] k);
    case (k)
      AK_V4:   atyp_code = ATYP_V4;
      AK_V6:   atyp_code = ATYP_V6;
      default: atyp_code = ATYP_NAME;
    endcase
  endfunction

endpackage

// ===== hdl/s5ch_front.sv =====
// ----------------------------------------------------------------------------
// s5ch_front
// Accepts items, runs the handshake state and pushes at most one burst per item.
// ----------------------------------------------------------------------------
module s5ch_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_opcode,
  input  logic [7:0]            in_data_byte,
  input  logic [1:0]            in_addr_kind,
  input  logic [7:0]            in_name_length,
  input  logic [15:0]           in_target_port_in,
  input  logic [23:0]           in_timeout_ticks,
  input  logic                  q_full,
  output logic                  push,
  output s5ch_pkg::burst_desc_t push_desc
);
  import s5ch_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  byte_index_r, byte_index_nxt;
  logic [8:0]  skip_left_r, skip_left_nxt;
  logic [1:0]  target_kind_r, target_kind_nxt;
  logic [7:0]  target_length_r, target_length_nxt;
  logic [15:0] port_hold_r, port_hold_nxt;
  logic [23:0] ticks_left_r, ticks_left_nxt;

  logic       accept;
  logic [7:0] bi_inc;
  logic [8:0] skip_dec;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign bi_inc   = byte_index_r + 8'd1;
  assign skip_dec = (skip_left_r != 9'd0) ? skip_left_r - 9'd1 : skip_left_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      byte_index_r    <= '0;
      skip_left_r     <= '0;
      target_kind_r   <= '0;
      target_length_r <= '0;
      port_hold_r     <= '0;
      ticks_left_r    <= '0;
    end else begin
      phase_r         <= phase_nxt;
      byte_index_r    <= byte_index_nxt;
      skip_left_r     <= skip_left_nxt;
      target_kind_r   <= target_kind_nxt;
      target_length_r <= target_length_nxt;
      port_hold_r     <= port_hold_nxt;
      ticks_left_r    <= ticks_left_nxt;
    end
  end

  always_comb begin
    phase_nxt         = phase_r;
    byte_index_nxt    = byte_index_r;
    skip_left_nxt     = skip_left_r;
    target_kind_nxt   = target_kind_r;
    target_length_nxt = target_length_r;
    port_hold_nxt     = port_hold_r;
    ticks_left_nxt    = ticks_left_r;
    push              = 1'b0;
    push_desc         = '0;
    push_desc.kind    = BK_STATUS;
    push_desc.port    = port_hold_r;

    if (accept) begin
      case (opcode_t'(in_opcode))
        OP_START: begin
          push = 1'b1;
          if (in_addr_kind == AK_INVALID) begin
            push_desc.status = ST_BAD_TYPE;
            phase_nxt        = PH_IDLE;
          end else begin
            push_desc.kind    = BK_GREET;
            target_kind_nxt   = in_addr_kind;
            target_length_nxt = (in_addr_kind == AK_V4) ? LEN_V4 :
                                (in_addr_kind == AK_V6) ? LEN_V6 : in_name_length;
            port_hold_nxt     = in_target_port_in;
            ticks_left_nxt    = in_timeout_ticks;
            byte_index_nxt    = '0;
            skip_left_nxt     = '0;
            phase_nxt         = PH_GREET;
          end
        end

        OP_ADDR_BYTE: begin
          if (phase_r == PH_ADDR && byte_index_r < target_length_r) begin
            push            = 1'b1;
            push_desc.kind  = BK_ADDR;
            push_desc.first = in_data_byte;
            byte_index_nxt  = bi_inc;
            if (bi_inc >= target_length_r) begin
              push_desc.with_port = 1'b1;
              phase_nxt           = PH_HDR;
              byte_index_nxt      = '0;
            end
          end
        end

        OP_RX_BYTE: begin
          case (phase_r)
            PH_GREET: begin
              if (byte_index_r == 8'd0) begin
                if (in_data_byte != SOCKS_VER) begin
                  push             = 1'b1;
                  push_desc.status = ST_BAD_GREET;
                  phase_nxt        = PH_IDLE;
                end else begin
                  byte_index_nxt = 8'd1;
                end
              end else if (in_data_byte != AUTH_NONE) begin
                push             = 1'b1;
                push_desc.status = ST_BAD_GREET;
                phase_nxt        = PH_IDLE;
              end else begin
                // method accepted: request header, address follows
                push              = 1'b1;
                push_desc.kind    = BK_HDR;
                push_desc.first   = atyp_code(target_kind_r);
                push_desc.has_len = (target_kind_r == AK_NAME);
                push_desc.len     = target_length_r;
                phase_nxt         = PH_ADDR;
                byte_index_nxt    = '0;
                if (target_length_r == 8'd0) begin
                  push_desc.with_port = 1'b1;
                  phase_nxt           = PH_HDR;
                end
              end
            end
            PH_ADDR: begin
              push             = 1'b1;
              push_desc.status = ST_UNEXPECTED;
              phase_nxt        = PH_IDLE;
            end
            PH_HDR: begin
              case (byte_index_r)
                8'd0: begin
                  if (in_data_byte != SOCKS_VER) begin
                    push             = 1'b1;
                    push_desc.status = ST_BAD_VER;
                    phase_nxt        = PH_IDLE;
                  end else begin
                    byte_index_nxt = bi_inc;
                  end
                end
                8'd1: begin
                  if (in_data_byte != REPLY_OK) begin
                    push             = 1'b1;
                    push_desc.status = ST_REFUSED;
                    push_desc.code   = in_data_byte;
                    phase_nxt        = PH_IDLE;
                  end else begin
                    byte_index_nxt = bi_inc;
                  end
                end
                8'd3: begin
                  byte_index_nxt = '0;
                  if (in_data_byte == ATYP_V4) begin
                    skip_left_nxt = SKIP_V4;
                    phase_nxt     = PH_SKIP;
                  end else if (in_data_byte == ATYP_V6) begin
                    skip_left_nxt = SKIP_V6;
                    phase_nxt     = PH_SKIP;
                  end else if (in_data_byte == ATYP_NAME) begin
                    phase_nxt = PH_BLEN;
                  end else begin
                    push             = 1'b1;
                    push_desc.status = ST_BAD_TYPE;
                    phase_nxt        = PH_IDLE;
                  end
                end
                default: byte_index_nxt = bi_inc;
              endcase
            end
            PH_BLEN: begin
              skip_left_nxt = {1'b0, in_data_byte} + SKIP_PORT;
              phase_nxt     = PH_SKIP;
            end
            PH_SKIP: begin
              skip_left_nxt = skip_dec;
              if (skip_dec == 9'd0) begin
                push             = 1'b1;
                push_desc.status = ST_DONE;
                phase_nxt        = PH_IDLE;
              end
            end
            default: ;
          endcase
        end

        OP_TICK: begin
          if (phase_r != PH_IDLE) begin
            if (ticks_left_r == 24'd0) begin
              push             = 1'b1;
              push_desc.status = ST_TIMEOUT;
              phase_nxt        = PH_IDLE;
            end else begin
              ticks_left_nxt = ticks_left_r - 24'd1;
            end
          end
        end

        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/s5ch_queue.sv =====
// ----------------------------------------------------------------------------
// s5ch_queue
// Short FIFO of burst descriptors between front and back.
// ----------------------------------------------------------------------------
module s5ch_queue #(
  parameter int DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  s5ch_pkg::burst_desc_t push_desc,
  output logic                  full,
  input  logic                  pop,
  output logic                  head_valid,
  output s5ch_pkg::burst_desc_t head_desc
);
  import s5ch_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  burst_desc_t     mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_desc  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

// ===== hdl/s5ch_back.sv =====
// ----------------------------------------------------------------------------
// s5ch_back
// Expands each burst descriptor into result items, one per cycle unless out_ready stalls.
// ----------------------------------------------------------------------------
module s5ch_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  s5ch_pkg::burst_desc_t q_desc,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_kind,
  output logic [7:0]            out_tx_byte,
  output logic [2:0]            out_status,
  output logic [7:0]            out_reply_code,
  output logic                  out_last
);
  import s5ch_pkg::*;

  logic [2:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       kind_r, last_r;
  logic [7:0] tx_r, code_r;
  logic [2:0] status_r;

  logic [2:0] cnt;
  logic [2:0] j, p;
  logic [7:0] byte_c;
  logic       kind_c, last_c, advance;

  // byte at position idx_r of the current burst
  always_comb begin
    cnt    = 3'd1;
    byte_c = 8'h00;
    kind_c = RK_BYTE;
    j      = idx_r - 3'd4;
    p      = '0;
    case (q_desc.kind)
      BK_GREET: begin
        cnt = 3'd3;
        case (idx_r)
          3'd0:    byte_c = SOCKS_VER;
          3'd1:    byte_c = METHOD_COUNT;
          default: byte_c = AUTH_NONE;
        endcase
      end
      BK_HDR: begin
        cnt = 3'd4 + {2'b00, q_desc.has_len} + {1'b0, q_desc.with_port, 1'b0};
        p   = j - {2'b00, q_desc.has_len};
        case (idx_r)
          3'd0: byte_c = SOCKS_VER;
          3'd1: byte_c = REQ_CONNECT;
          3'd2: byte_c = RSV_BYTE;
          3'd3: byte_c = q_desc.first;
          default: begin
            if (q_desc.has_len && j == 3'd0) begin
              byte_c = q_desc.len;
            end else begin
              byte_c = (p == 3'd0) ? q_desc.port[15:8] : q_desc.port[7:0];
            end
          end
        endcase
      end
      BK_ADDR: begin
        cnt = 3'd1 + {1'b0, q_desc.with_port, 1'b0};
        case (idx_r)
          3'd0:    byte_c = q_desc.first;
          3'd1:    byte_c = q_desc.port[15:8];
          default: byte_c = q_desc.port[7:0];
        endcase
      end
      default: kind_c = RK_STATUS;
    endcase
  end

  assign last_c  = (idx_r == cnt - 3'd1);
  assign advance = q_valid && (!out_valid_r || out_ready);
  assign q_pop   = advance && last_c;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (advance) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = last_c ? 3'd0 : idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      kind_r   <= kind_c;
      tx_r     <= (kind_c == RK_STATUS) ? 8'h00 : byte_c;
      status_r <= (kind_c == RK_STATUS) ? q_desc.status : ST_DONE;
      code_r   <= (kind_c == RK_STATUS) ? q_desc.code : 8'h00;
      last_r   <= last_c;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = kind_r;
  assign out_tx_byte    = tx_r;
  assign out_status     = status_r;
  assign out_reply_code = code_r;
  assign out_last       = last_r;

endmodule

// ===== hdl/socks5_client_handshake_top.sv =====
// An accepted item's descriptor is queued first; the back end then registers its results.
// Throughput: one item per cycle while the descriptor queue has room; results leave
//   one per cycle unless out_ready stalls, and an item causes up to seven results.
// The back end's single output register is the rate limit for result-heavy traffic.
// Reset: synchronous, active low; handshake goes idle, queue empties, no result valid.
// ----------------------------------------------------------------------------
// socks5_client_handshake_top
// SOCKS5 no-auth CONNECT client handshake: front state machine, descriptor
// queue, and a back end that serializes result bursts.
// ----------------------------------------------------------------------------
module socks5_client_handshake_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_data_byte,
  input  logic [1:0]  in_addr_kind,
  input  logic [7:0]  in_name_length,
  input  logic [15:0] in_target_port_in,
  input  logic [23:0] in_timeout_ticks,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [7:0]  out_tx_byte,
  output logic [2:0]  out_status,
  output logic [7:0]  out_reply_code,
  output logic        out_last
);
  import s5ch_pkg::*;

  // Front: every accepted item updates the registered handshake state and
  // pushes at most one burst descriptor (greeting, header, address byte with
  // optional port, or a status report). Items with no result push nothing.
  logic        push, q_full, q_valid, q_pop;
  burst_desc_t push_desc, head_desc;

  s5ch_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_data_byte      (in_data_byte),
    .in_addr_kind      (in_addr_kind),
    .in_name_length    (in_name_length),
    .in_target_port_in (in_target_port_in),
    .in_timeout_ticks  (in_timeout_ticks),
    .q_full            (q_full),
    .push              (push),
    .push_desc         (push_desc)
  );

  // Queue decouples the front from output back-pressure.
  s5ch_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_desc  (push_desc),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_desc  (head_desc)
  );

  // Back: walks the head descriptor one result per cycle unless out_ready stalls; pops on its last.
  s5ch_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_desc         (head_desc),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_tx_byte    (out_tx_byte),
    .out_status     (out_status),
    .out_reply_code (out_reply_code),
    .out_last       (out_last)
  );

endmodule

// ===== hdl/s5ch_checker.sv =====
// ----------------------------------------------------------------------------
// s5ch_checker
// Port-level checks on the handshake block, bound to the top level.
// ----------------------------------------------------------------------------
`include "socks5_client_handshake_top_assert.svh"

module s5ch_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_kind,
  input logic [2:0] out_status,
  input logic [7:0] out_reply_code,
  input logic       out_last
);
  import s5ch_pkg::*;

  // stalled result stays offered
  `S5CH_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  // a status report always ends its item's burst
  `S5CH_ASSERT_NOW(a_status_last, clk, rst_n, out_valid && out_kind == RK_STATUS, out_last)
  // byte results carry no status
  `S5CH_ASSERT_NOW(a_byte_clean, clk, rst_n, out_valid && out_kind == RK_BYTE, out_status == ST_DONE && out_reply_code == 8'h00)

endmodule

bind socks5_client_handshake_top s5ch_checker u_s5ch_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_kind       (out_kind),
  .out_status     (out_status),
  .out_reply_code (out_reply_code),
  .out_last       (out_last)
);
